// ===== hw/rtl/pcbr_pkg.sv =====
`timescale 1ns / 1ps
// pcbr_pkg: shared constants and types of the point cloud box remover
// no dependencies

package pcbr_pkg;

    localparam int COORD_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PAD_BITS      = 20;
    localparam int QUEUE_DEPTH   = 4;
    localparam int SENTINEL_M    = 9999;

    localparam logic [PAD_BITS-1:0] PAD_RESET = 20'd328;

    localparam logic OP_OBJECT = 1'b0;
    localparam logic OP_SCENE  = 1'b1;

    typedef struct packed {
        logic first;
        logic changed;
        logic ok;
        logic last;
    } t_scene_ctrl;

    localparam int SCENE_CTRL_W = $bits(t_scene_ctrl);

endpackage

// ===== hw/rtl/pcbr_front.sv =====
`timescale 1ns / 1ps
// pcbr_front: accepts points, tracks the object box, opens scenes and pads the box
// depends on pcbr_pkg

module pcbr_front #(
    parameter int COORD_BITS    = pcbr_pkg::COORD_BITS,
    parameter int FRACTION_BITS = pcbr_pkg::FRACTION_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [pcbr_pkg::PAD_BITS-1:0]      i_cfg_wr_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [3*COORD_BITS-1:0]            i_coords,
    input  logic                               i_opcode,
    input  logic                               i_ok,
    input  logic                               i_last,
    input  logic                               i_full,
    output logic                               o_push,
    output logic [3*COORD_BITS-1:0]            o_coords,
    output logic [6*COORD_BITS-1:0]            o_box,
    output pcbr_pkg::t_scene_ctrl              o_ctrl
);
    import pcbr_pkg::*;

    localparam int EXT = ((COORD_BITS > PAD_BITS) ? COORD_BITS : PAD_BITS) + 1;
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] SENT =
        (COORD_BITS >= FRACTION_BITS + 15) ?
        COORD_BITS'(64'(SENTINEL_M) << FRACTION_BITS) : CMAX;
    localparam logic signed [COORD_BITS-1:0] SENT_NEG = -SENT;
    localparam logic signed [EXT-1:0] CMAX_X = {{(EXT-COORD_BITS){1'b0}}, CMAX};
    localparam logic signed [EXT-1:0] CMIN_X = {{(EXT-COORD_BITS){1'b1}}, CMIN};

    logic signed [COORD_BITS-1:0] r_run_min [3];
    logic signed [COORD_BITS-1:0] r_run_max [3];
    logic signed [COORD_BITS-1:0] n_run_min [3];
    logic signed [COORD_BITS-1:0] n_run_max [3];
    logic signed [COORD_BITS-1:0] r_commit  [6];
    logic signed [COORD_BITS-1:0] r_prev    [6];
    logic signed [COORD_BITS-1:0] pad_box   [6];
    logic signed [COORD_BITS-1:0] c         [3];
    logic signed [EXT-1:0]        lo_x      [3];
    logic signed [EXT-1:0]        hi_x      [3];
    logic signed [EXT-1:0]        pad_x;
    logic [PAD_BITS-1:0]          r_pad;
    logic                         r_scene_active;
    logic                         accept;
    logic                         obj_acc;
    logic                         scn_acc;
    logic                         box_diff;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign obj_acc = accept && (i_opcode == OP_OBJECT);
    assign scn_acc = accept && (i_opcode == OP_SCENE);
    assign pad_x   = {{(EXT-PAD_BITS){1'b0}}, r_pad};

    always_comb begin
        box_diff = 1'b0;
        for (int k = 0; k < 6; k++) begin
            if (r_commit[k] != r_prev[k]) begin
                box_diff = 1'b1;
            end
        end
        for (int a = 0; a < 3; a++) begin
            c[a] = i_coords[a*COORD_BITS +: COORD_BITS];
            n_run_min[a] = (i_ok && (c[a] < r_run_min[a])) ? c[a] : r_run_min[a];
            n_run_max[a] = (i_ok && (c[a] > r_run_max[a])) ? c[a] : r_run_max[a];
            lo_x[a] = {{(EXT-COORD_BITS){r_commit[2*a][COORD_BITS-1]}}, r_commit[2*a]}
                      - pad_x;
            hi_x[a] = {{(EXT-COORD_BITS){r_commit[2*a+1][COORD_BITS-1]}}, r_commit[2*a+1]}
                      + pad_x;
            pad_box[2*a]   = (lo_x[a] < CMIN_X) ? CMIN : lo_x[a][COORD_BITS-1:0];
            pad_box[2*a+1] = (hi_x[a] > CMAX_X) ? CMAX : hi_x[a][COORD_BITS-1:0];
        end
        for (int k = 0; k < 6; k++) begin
            o_box[k*COORD_BITS +: COORD_BITS] = pad_box[k];
        end
    end

    assign o_push          = scn_acc;
    assign o_coords        = i_coords;
    assign o_ctrl.first    = !r_scene_active;
    assign o_ctrl.changed  = !r_scene_active && box_diff;
    assign o_ctrl.ok       = i_ok;
    assign o_ctrl.last     = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_run_min[a] <= SENT;
                r_run_max[a] <= SENT_NEG;
            end
            for (int k = 0; k < 6; k++) begin
                r_commit[k] <= '0;
                r_prev[k]   <= '0;
            end
            r_scene_active <= 1'b0;
            r_pad          <= PAD_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_pad <= i_cfg_wr_data;
            end
            if (obj_acc) begin
                if (i_last) begin
                    for (int a = 0; a < 3; a++) begin
                        r_commit[2*a]   <= n_run_min[a];
                        r_commit[2*a+1] <= n_run_max[a];
                        r_run_min[a]    <= SENT;
                        r_run_max[a]    <= SENT_NEG;
                    end
                end else begin
                    for (int a = 0; a < 3; a++) begin
                        r_run_min[a] <= n_run_min[a];
                        r_run_max[a] <= n_run_max[a];
                    end
                end
            end
            if (scn_acc) begin
                if (!r_scene_active) begin
                    for (int k = 0; k < 6; k++) begin
                        r_prev[k] <= r_commit[k];
                    end
                end
                r_scene_active <= !i_last;
            end
        end
    end

    // object cloud end restarts the running bounds
    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (obj_acc && i_last) |=> (r_run_min[0] == SENT && r_run_max[2] == SENT_NEG))
        else $error("running bounds not restarted after commit");

    // first scene point copies committed box into previous box
    a_prev_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scn_acc && !r_scene_active) |=> (r_prev[1] == $past(r_commit[1])))
        else $error("previous box not updated at scene start");

endmodule

// ===== hw/rtl/pcbr_queue.sv =====
`timescale 1ns / 1ps
// pcbr_queue: small register queue between front and back
// depends on pcbr_pkg

module pcbr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pcbr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import pcbr_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [COUNT_W-1:0] r_count;

    assign o_full  = (r_count == COUNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/pcbr_back.sv =====
`timescale 1ns / 1ps
// pcbr_back: latches the scene box, tests scene points against it, output register
// depends on pcbr_pkg

module pcbr_back #(
    parameter int COORD_BITS = pcbr_pkg::COORD_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_pop,
    input  logic [3*COORD_BITS-1:0]  i_coords,
    input  logic [6*COORD_BITS-1:0]  i_box,
    input  pcbr_pkg::t_scene_ctrl    i_ctrl,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [3*COORD_BITS-1:0]  o_coords,
    output logic                     o_ok,
    output logic                     o_removed,
    output logic                     o_changed,
    output logic                     o_last
);
    import pcbr_pkg::*;

    logic signed [COORD_BITS-1:0] r_box [6];
    logic signed [COORD_BITS-1:0] sel_box [6];
    logic signed [COORD_BITS-1:0] c [3];
    logic [3*COORD_BITS-1:0]      r_coords;
    logic                         r_valid;
    logic                         r_ok;
    logic                         r_removed;
    logic                         r_changed;
    logic                         r_last;
    logic                         in_box;

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_comb begin
        in_box = i_ctrl.ok;
        for (int k = 0; k < 6; k++) begin
            sel_box[k] = i_ctrl.first ? i_box[k*COORD_BITS +: COORD_BITS] : r_box[k];
        end
        for (int a = 0; a < 3; a++) begin
            c[a] = i_coords[a*COORD_BITS +: COORD_BITS];
            if ((c[a] < sel_box[2*a]) || (c[a] > sel_box[2*a+1])) begin
                in_box = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_ctrl.first) begin
                for (int k = 0; k < 6; k++) begin
                    r_box[k] <= sel_box[k];
                end
            end
            r_coords  <= i_coords;
            r_ok      <= i_ctrl.ok && !in_box;
            r_removed <= in_box;
            r_changed <= i_ctrl.changed;
            r_last    <= i_ctrl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid   = r_valid;
    assign o_coords  = r_coords;
    assign o_ok      = r_ok;
    assign o_removed = r_removed;
    assign o_changed = r_changed;
    assign o_last    = r_last;

    a_removed_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_ok && r_removed))
        else $error("removed point still marked valid");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !o_pop)
        else $error("queue popped while output stalled");

endmodule

// ===== hw/rtl/point_cloud_box_remover.sv =====
`timescale 1ns / 1ps
// point_cloud_box_remover: top level, crop-box remover on a shared point stream
// depends on pcbr_pkg, pcbr_front, pcbr_queue, pcbr_back
//
// channel   dir  handshake                      content
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata x,y,z; tuser opcode,point_ok; tlast
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata x,y,z; tuser ok,removed,changed; tlast
// cfg       in   i_cfg_wr_en                    box padding, Q.FRACTION_BITS metres
//
// one point per cycle while the queue has room; scene points go via queue and output register
// object points give no result and only update the box registers in the front
// front and back are parted by a four-entry queue; s_axis_tready drops only when it is full
// synchronous active-low reset; no clearing pass, box registers reset at once

module point_cloud_box_remover #(
    parameter int COORD_BITS    = pcbr_pkg::COORD_BITS,
    parameter int FRACTION_BITS = pcbr_pkg::FRACTION_BITS,
    parameter int QUEUE_DEPTH   = pcbr_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // coord_x, coord_y, coord_z, zero fill
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // opcode, point_ok
    input  logic [1:0]                             s_axis_tuser,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_x, out_y, out_z, zero fill
    output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // out_ok, removed, box_changed
    output logic [2:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  logic                                   i_cfg_wr_en,
    input  logic [pcbr_pkg::PAD_BITS-1:0]          i_cfg_wr_data
);
    import pcbr_pkg::*;

    localparam int TDATA_W = ((3*COORD_BITS+7)/8)*8;
    localparam int QW      = 9*COORD_BITS + SCENE_CTRL_W;

    logic                    fe_push;
    logic [3*COORD_BITS-1:0] fe_coords;
    logic [6*COORD_BITS-1:0] fe_box;
    t_scene_ctrl             fe_ctrl;
    logic                    q_full;
    logic                    q_valid;
    logic                    q_pop;
    logic [QW-1:0]           q_data;
    t_scene_ctrl             be_ctrl;
    logic [3*COORD_BITS-1:0] be_coords;
    logic                    be_ok;
    logic                    be_removed;
    logic                    be_changed;

    pcbr_front #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_coords      (s_axis_tdata[3*COORD_BITS-1:0]),
        .i_opcode      (s_axis_tuser[0]),
        .i_ok          (s_axis_tuser[1]),
        .i_last        (s_axis_tlast),
        .i_full        (q_full),
        .o_push        (fe_push),
        .o_coords      (fe_coords),
        .o_box         (fe_box),
        .o_ctrl        (fe_ctrl)
    );

    pcbr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  ({fe_box, fe_coords, fe_ctrl}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    assign be_ctrl = t_scene_ctrl'(q_data[SCENE_CTRL_W-1:0]);

    pcbr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_pop     (q_pop),
        .i_coords  (q_data[SCENE_CTRL_W +: 3*COORD_BITS]),
        .i_box     (q_data[SCENE_CTRL_W + 3*COORD_BITS +: 6*COORD_BITS]),
        .i_ctrl    (be_ctrl),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_coords  (be_coords),
        .o_ok      (be_ok),
        .o_removed (be_removed),
        .o_changed (be_changed),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_W'(be_coords);
    assign m_axis_tuser = {be_changed, be_removed, be_ok};

endmodule
